// ----- rtl/msfd_pkg.sv -----
// Shared types, constants and the CRC-32 byte step for the frame decoder.
package msfd_pkg;

   // Store geometry
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

   // Frame layout
   localparam int HDR_LEN     = 18;
   localparam int CRC_LEN     = 4;
   localparam int MAX_PAYLOAD = 32;
   localparam int MAGIC_LEN   = 4;

   localparam logic [7:0] MAGIC_0 = 8'h4D;   // M
   localparam logic [7:0] MAGIC_1 = 8'h50;   // P
   localparam logic [7:0] MAGIC_2 = 8'h43;   // C
   localparam logic [7:0] MAGIC_3 = 8'h46;   // F

   localparam logic [15:0] CMD_LOW  = 16'd1;
   localparam logic [15:0] CMD_HIGH = 16'd10;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // Result kinds and error codes
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_TOO_LARGE   = 2'd0;
   localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
   localparam logic [1:0] ERR_BAD_COMMAND = 2'd2;
   localparam logic [1:0] ERR_CRC         = 2'd3;

   // Configuration register indexes
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_PAYLOAD_LIMIT    = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRE_START, ST_PRE_SCAN, ST_PRE_DROP,
      ST_APPEND,
      ST_CHK_START, ST_CHK_SCAN, ST_CHK_DROP,
      ST_HDR_DECIDE, ST_HDR_START, ST_HDR_SCAN, ST_HDR_EVAL,
      ST_OVR_EMIT, ST_OVR_START, ST_OVR_SCAN, ST_OVR_DROP,
      ST_BODY_START, ST_BODY_SCAN, ST_VERDICT,
      ST_PREAD, ST_PLOAD, ST_FDROP
   } state_type;

   typedef enum logic [2:0] {
      SW_NONE,
      SW_SCAN_FROM0,
      SW_SCAN_FROM1,
      SW_HEADER,
      SW_BODY
   } sweep_type;

   typedef enum logic [1:0] {
      OUT_HEADER,
      OUT_PAYLOAD,
      OUT_ERROR
   } out_sel_type;

   typedef struct packed {
      logic        append;
      sweep_type   sweep;
      logic        drop_scan;
      logic        drop_frame;
      logic        out_load;
      out_sel_type out_sel;
      logic [1:0]  err_code;
      logic        pay_clear;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic sweep_done;
      logic below_header;
      logic oversize;
      logic short_frame;
      logic ver_bad;
      logic cmd_bad;
      logic crc_bad;
      logic plen_zero;
      logic pay_last;
      logic out_free;
   } status_type;

   // One byte through the reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
      logic [31:0] c;
      c = crc_in ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/msfd_ctrl.sv -----
// Sequencing state machine of the frame decoder.
module msfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  msfd_pkg::status_type status,
   output msfd_pkg::cmd_type    cmd,
   output logic                 busy
);

   msfd_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msfd_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = status.full ? msfd_pkg::ST_PRE_START : msfd_pkg::ST_APPEND;
            end
         end
         msfd_pkg::ST_PRE_START: state_in = msfd_pkg::ST_PRE_SCAN;
         msfd_pkg::ST_PRE_SCAN: begin
            if (status.sweep_done) state_in = msfd_pkg::ST_PRE_DROP;
         end
         msfd_pkg::ST_PRE_DROP:  state_in = msfd_pkg::ST_APPEND;
         msfd_pkg::ST_APPEND:    state_in = msfd_pkg::ST_CHK_START;
         msfd_pkg::ST_CHK_START: state_in = msfd_pkg::ST_CHK_SCAN;
         msfd_pkg::ST_CHK_SCAN: begin
            if (status.sweep_done) state_in = msfd_pkg::ST_CHK_DROP;
         end
         msfd_pkg::ST_CHK_DROP: state_in = msfd_pkg::ST_HDR_DECIDE;
         msfd_pkg::ST_HDR_DECIDE: begin
            state_in = status.below_header ? msfd_pkg::ST_IDLE : msfd_pkg::ST_HDR_START;
         end
         msfd_pkg::ST_HDR_START: state_in = msfd_pkg::ST_HDR_SCAN;
         msfd_pkg::ST_HDR_SCAN: begin
            if (status.sweep_done) state_in = msfd_pkg::ST_HDR_EVAL;
         end
         msfd_pkg::ST_HDR_EVAL: begin
            if (status.oversize)         state_in = msfd_pkg::ST_OVR_EMIT;
            else if (status.short_frame) state_in = msfd_pkg::ST_IDLE;
            else                         state_in = msfd_pkg::ST_BODY_START;
         end
         msfd_pkg::ST_OVR_EMIT: begin
            if (status.out_free) state_in = msfd_pkg::ST_OVR_START;
         end
         msfd_pkg::ST_OVR_START: state_in = msfd_pkg::ST_OVR_SCAN;
         msfd_pkg::ST_OVR_SCAN: begin
            if (status.sweep_done) state_in = msfd_pkg::ST_OVR_DROP;
         end
         msfd_pkg::ST_OVR_DROP:   state_in = msfd_pkg::ST_IDLE;
         msfd_pkg::ST_BODY_START: state_in = msfd_pkg::ST_BODY_SCAN;
         msfd_pkg::ST_BODY_SCAN: begin
            if (status.sweep_done) state_in = msfd_pkg::ST_VERDICT;
         end
         msfd_pkg::ST_VERDICT: begin
            if (status.out_free) begin
               if (status.ver_bad || status.cmd_bad || status.crc_bad || status.plen_zero) begin
                  state_in = msfd_pkg::ST_FDROP;
               end else begin
                  state_in = msfd_pkg::ST_PREAD;
               end
            end
         end
         msfd_pkg::ST_PREAD: state_in = msfd_pkg::ST_PLOAD;
         msfd_pkg::ST_PLOAD: begin
            if (status.out_free) begin
               state_in = status.pay_last ? msfd_pkg::ST_FDROP : msfd_pkg::ST_PREAD;
            end
         end
         msfd_pkg::ST_FDROP: state_in = msfd_pkg::ST_IDLE;
         default:            state_in = msfd_pkg::ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd            = '0;
      cmd.sweep      = msfd_pkg::SW_NONE;
      cmd.out_sel    = msfd_pkg::OUT_ERROR;
      cmd.err_code   = msfd_pkg::ERR_TOO_LARGE;
      busy           = 1'b1;
      unique case (state_ff)
         msfd_pkg::ST_IDLE:       busy = 1'b0;
         msfd_pkg::ST_PRE_START:  cmd.sweep = msfd_pkg::SW_SCAN_FROM1;
         msfd_pkg::ST_PRE_DROP:   cmd.drop_scan = 1'b1;
         msfd_pkg::ST_APPEND:     cmd.append = 1'b1;
         msfd_pkg::ST_CHK_START:  cmd.sweep = msfd_pkg::SW_SCAN_FROM0;
         msfd_pkg::ST_CHK_DROP:   cmd.drop_scan = 1'b1;
         msfd_pkg::ST_HDR_START:  cmd.sweep = msfd_pkg::SW_HEADER;
         msfd_pkg::ST_OVR_EMIT: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = msfd_pkg::OUT_ERROR;
            cmd.err_code = msfd_pkg::ERR_TOO_LARGE;
         end
         msfd_pkg::ST_OVR_START:  cmd.sweep = msfd_pkg::SW_SCAN_FROM1;
         msfd_pkg::ST_OVR_DROP:   cmd.drop_scan = 1'b1;
         msfd_pkg::ST_BODY_START: cmd.sweep = msfd_pkg::SW_BODY;
         msfd_pkg::ST_VERDICT: begin
            cmd.out_load  = status.out_free;
            cmd.pay_clear = 1'b1;
            if (status.ver_bad) begin
               cmd.err_code = msfd_pkg::ERR_BAD_VERSION;
            end else if (status.cmd_bad) begin
               cmd.err_code = msfd_pkg::ERR_BAD_COMMAND;
            end else if (status.crc_bad) begin
               cmd.err_code = msfd_pkg::ERR_CRC;
            end else begin
               cmd.out_sel = msfd_pkg::OUT_HEADER;
            end
         end
         msfd_pkg::ST_PLOAD: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = msfd_pkg::OUT_PAYLOAD;
         end
         msfd_pkg::ST_FDROP:      cmd.drop_frame = 1'b1;
         default:                 busy = 1'b1;
      endcase
   end

endmodule

// ----- rtl/msfd_dpath.sv -----
// Byte store, sweep engine, header/CRC capture and result register.
module msfd_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  logic [7:0]           req_data_byte,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data,
   input  msfd_pkg::cmd_type    cmd,
   output msfd_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [1:0]           rsp_error_code,
   output logic [31:0]          rsp_transaction_id,
   output logic [3:0]           rsp_command_code,
   output logic [15:0]          rsp_frame_flags,
   output logic [5:0]           rsp_payload_count,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_last
);

   localparam int AW = msfd_pkg::ADDR_W;
   localparam int FW = msfd_pkg::FILL_W;

   // Configuration
   logic [15:0] ver_cfg_ff;
   logic [5:0]  lim_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_cfg_ff <= 16'd1;
         lim_cfg_ff <= 6'(msfd_pkg::MAX_PAYLOAD);
      end else if (csr_valid) begin
         if (csr_index == msfd_pkg::CSR_EXPECTED_VERSION) ver_cfg_ff <= csr_data;
         else                                             lim_cfg_ff <= csr_data[5:0];
      end
   end

   // Incoming byte holding register
   logic [7:0] in_byte_ff;
   always_ff @(posedge clock) begin
      if (req_accept) in_byte_ff <= req_data_byte;
   end

   // Store pointers
   logic [AW-1:0] head_ff;
   logic [FW-1:0] fill_ff;

   // Sweep engine
   logic          active_ff, rvld_ff, found_ff, from1_ff, body_ff;
   logic [FW-1:0] idx_ff, end_ff, ridx_ff, fpos_ff;
   logic [7:0]    rd_ff;
   logic [23:0]   win_ff;
   logic [5:0]    pi_ff;

   // Header fields and CRC
   logic [15:0] ver_ff, cmd_ff, flg_ff;
   logic [31:0] rid_ff, plen_ff, crc_ff, crc_rx_ff;

   logic [AW-1:0] wr_addr, rd_addr, pay_addr;
   logic [FW-1:0] flen, crc_end, sweep_start, sweep_end, drop_n;
   logic [5:0]    limit;
   logic          match;

   assign limit    = (lim_cfg_ff < 6'(msfd_pkg::MAX_PAYLOAD)) ? lim_cfg_ff
                                                              : 6'(msfd_pkg::MAX_PAYLOAD);
   assign crc_end  = FW'(msfd_pkg::HDR_LEN) + FW'(plen_ff[5:0]);
   assign flen     = crc_end + FW'(msfd_pkg::CRC_LEN);
   assign wr_addr  = head_ff + fill_ff[AW-1:0];
   assign pay_addr = AW'(msfd_pkg::HDR_LEN) + pi_ff;
   assign rd_addr  = head_ff + (active_ff ? idx_ff[AW-1:0] : pay_addr);

   // Sweep range per request kind
   always_comb begin
      sweep_start = '0;
      sweep_end   = fill_ff;
      case (cmd.sweep)
         msfd_pkg::SW_HEADER: sweep_end = FW'(msfd_pkg::HDR_LEN);
         msfd_pkg::SW_BODY: begin
            sweep_start = FW'(msfd_pkg::HDR_LEN);
            sweep_end   = flen;
         end
         default: sweep_end = fill_ff;
      endcase
   end

   // Magic match on the byte now arriving from the store
   assign match = rvld_ff && !body_ff && !found_ff &&
                  (win_ff[23:16] == msfd_pkg::MAGIC_0) && (win_ff[15:8] == msfd_pkg::MAGIC_1) &&
                  (win_ff[7:0] == msfd_pkg::MAGIC_2) && (rd_ff == msfd_pkg::MAGIC_3) &&
                  (ridx_ff >= FW'(msfd_pkg::MAGIC_LEN - 1)) &&
                  (!from1_ff || ridx_ff >= FW'(msfd_pkg::MAGIC_LEN));

   // Amount removed after a scan
   always_comb begin
      if (found_ff)        drop_n = fpos_ff;
      else if (fill_ff > FW'(3)) drop_n = fill_ff - FW'(3);
      else                 drop_n = '0;
   end

   // Memory
   logic [7:0] byte_store [msfd_pkg::STORE_DEPTH];
   always_ff @(posedge clock) begin
      if (cmd.append) byte_store[wr_addr] <= in_byte_ff;
      rd_ff <= byte_store[rd_addr];
   end

   // Control registers of the store and sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         active_ff <= 1'b0;
         rvld_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rvld_ff <= active_ff;
         if (cmd.sweep != msfd_pkg::SW_NONE) begin
            active_ff <= sweep_start < sweep_end;
            found_ff  <= 1'b0;
         end else if (match) begin
            active_ff <= 1'b0;
            found_ff  <= 1'b1;
         end else if (active_ff && (idx_ff + FW'(1) >= end_ff)) begin
            active_ff <= 1'b0;
         end
         if (cmd.append) begin
            fill_ff <= fill_ff + FW'(1);
         end else if (cmd.drop_scan) begin
            head_ff <= head_ff + drop_n[AW-1:0];
            fill_ff <= fill_ff - drop_n;
         end else if (cmd.drop_frame) begin
            head_ff <= head_ff + flen[AW-1:0];
            fill_ff <= fill_ff - flen;
         end
      end
   end

   // Sweep datapath: index, window, header fields, CRC
   always_ff @(posedge clock) begin
      if (cmd.sweep != msfd_pkg::SW_NONE) begin
         idx_ff   <= sweep_start;
         end_ff   <= sweep_end;
         from1_ff <= (cmd.sweep == msfd_pkg::SW_SCAN_FROM1);
         body_ff  <= (cmd.sweep == msfd_pkg::SW_HEADER) || (cmd.sweep == msfd_pkg::SW_BODY);
         if (cmd.sweep == msfd_pkg::SW_HEADER) crc_ff <= msfd_pkg::CRC_ONES;
      end else if (active_ff) begin
         idx_ff <= idx_ff + FW'(1);
      end
      ridx_ff <= idx_ff;
      if (match) fpos_ff <= ridx_ff - FW'(msfd_pkg::MAGIC_LEN - 1);
      if (rvld_ff) begin
         win_ff <= {win_ff[15:0], rd_ff};
         if (body_ff) begin
            if (ridx_ff < crc_end || ridx_ff < FW'(msfd_pkg::HDR_LEN)) begin
               crc_ff <= msfd_pkg::crc_byte(crc_ff, rd_ff);
            end else begin
               crc_rx_ff <= {rd_ff, crc_rx_ff[31:8]};
            end
            case (ridx_ff)
               FW'(4):  ver_ff[7:0]    <= rd_ff;
               FW'(5):  ver_ff[15:8]   <= rd_ff;
               FW'(6):  rid_ff[7:0]    <= rd_ff;
               FW'(7):  rid_ff[15:8]   <= rd_ff;
               FW'(8):  rid_ff[23:16]  <= rd_ff;
               FW'(9):  rid_ff[31:24]  <= rd_ff;
               FW'(10): cmd_ff[7:0]    <= rd_ff;
               FW'(11): cmd_ff[15:8]   <= rd_ff;
               FW'(12): flg_ff[7:0]    <= rd_ff;
               FW'(13): flg_ff[15:8]   <= rd_ff;
               FW'(14): plen_ff[7:0]   <= rd_ff;
               FW'(15): plen_ff[15:8]  <= rd_ff;
               FW'(16): plen_ff[23:16] <= rd_ff;
               FW'(17): plen_ff[31:24] <= rd_ff;
               default: ;
            endcase
         end
      end
   end

   // Payload counter
   always_ff @(posedge clock) begin
      if (cmd.pay_clear) begin
         pi_ff <= '0;
      end else if (cmd.out_load && cmd.out_sel == msfd_pkg::OUT_PAYLOAD) begin
         pi_ff <= pi_ff + 6'd1;
      end
   end

   // Result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff, err_ff;
   logic [31:0] orid_ff;
   logic [3:0]  ocmd_ff;
   logic [15:0] oflg_ff;
   logic [5:0]  ocnt_ff;
   logic [7:0]  opb_ff;
   logic        olast_ff;
   logic        pay_last;

   assign pay_last = ({1'b0, pi_ff} + 7'd1) == {1'b0, plen_ff[5:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff  <= msfd_pkg::KIND_ERROR;
         err_ff   <= cmd.err_code;
         orid_ff  <= '0;
         ocmd_ff  <= '0;
         oflg_ff  <= '0;
         ocnt_ff  <= '0;
         opb_ff   <= '0;
         olast_ff <= 1'b1;
         case (cmd.out_sel)
            msfd_pkg::OUT_HEADER: begin
               kind_ff  <= msfd_pkg::KIND_HEADER;
               err_ff   <= '0;
               orid_ff  <= rid_ff;
               ocmd_ff  <= cmd_ff[3:0];
               oflg_ff  <= flg_ff;
               ocnt_ff  <= plen_ff[5:0];
               olast_ff <= (plen_ff == 32'd0);
            end
            msfd_pkg::OUT_PAYLOAD: begin
               kind_ff  <= msfd_pkg::KIND_PAYLOAD;
               err_ff   <= '0;
               opb_ff   <= rd_ff;
               olast_ff <= pay_last;
            end
            default: kind_ff <= msfd_pkg::KIND_ERROR;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_transaction_id = orid_ff;
   assign rsp_command_code   = ocmd_ff;
   assign rsp_frame_flags    = oflg_ff;
   assign rsp_payload_count  = ocnt_ff;
   assign rsp_payload_byte   = opb_ff;
   assign rsp_last           = olast_ff;

   // Status back to the controller
   always_comb begin
      status              = '0;
      status.full         = fill_ff == FW'(msfd_pkg::STORE_DEPTH);
      status.sweep_done   = !active_ff && !rvld_ff;
      status.below_header = fill_ff < FW'(msfd_pkg::HDR_LEN);
      status.oversize     = plen_ff > {26'd0, limit};
      status.short_frame  = fill_ff < flen;
      status.ver_bad      = ver_ff != ver_cfg_ff;
      status.cmd_bad      = (cmd_ff < msfd_pkg::CMD_LOW) || (cmd_ff > msfd_pkg::CMD_HIGH);
      status.crc_bad      = (crc_ff ^ msfd_pkg::CRC_ONES) != crc_rx_ff;
      status.plen_zero    = plen_ff == 32'd0;
      status.pay_last     = pay_last;
      status.out_free     = !rsp_valid_ff;
   end

endmodule

// ----- rtl/magic_sync_frame_decoder_top.sv -----
// Frame decoder top level: request, result and register ports.
// A request holds the input while its byte is appended and the stored bytes are scanned
// for the magic; a full header adds a header read, and a complete frame a body read,
// the verdict and its results, and the input is held longer while rsp_stall holds a result.
// Synchronous active-high reset empties the store, restores version 1 and limit 32.
module magic_sync_frame_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_transaction_id,
   output logic [3:0]  rsp_command_code,
   output logic [15:0] rsp_frame_flags,
   output logic [5:0]  rsp_payload_count,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   msfd_pkg::cmd_type    cmd;
   msfd_pkg::status_type status;
   logic                 busy;
   logic                 req_accept;

   // Request handshake
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign csr_ready  = 1'b1;

   msfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   msfd_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_accept         (req_accept),
      .req_data_byte      (req_data_byte),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_transaction_id (rsp_transaction_id),
      .rsp_command_code   (rsp_command_code),
      .rsp_frame_flags    (rsp_frame_flags),
      .rsp_payload_count  (rsp_payload_count),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

endmodule
